FILE: hdl/tepq_pkg.sv
// ----------------------------------------------------------------------------
// tepq_pkg: shared types and codes of the timed event priority queue
// Item kinds, controller states and the command/status bundles that join
// the controller and the datapath.
// ----------------------------------------------------------------------------
package tepq_pkg;

  localparam int TIME_W     = 64;
  localparam int KIND_W     = 2;
  localparam int TAG_PORT_W = 8;

  localparam logic [KIND_W-1:0] KIND_SCHEDULE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EXPIRE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_CMP,
    ST_INS_SHIFT,
    ST_EMIT_ONE,
    ST_EMIT_DROP,
    ST_EXP_CHECK,
    ST_EXP_FIRE
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic cmp;
    logic ins;
    logic pop;
    logic emit;
    logic emit_fired;
    logic emit_status;
    logic emit_last;
  } dp_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] in_kind;
    logic              full;
    logic              due;
    logic              out_busy;
  } dp_sts_t;

endpackage

FILE: hdl/tepq_in_if.sv
// ----------------------------------------------------------------------------
// tepq_in_if: input channel of the event queue
// Carries one schedule, expire or query item per valid/ready handshake.
// ----------------------------------------------------------------------------
interface tepq_in_if;
  logic                              valid;
  logic                              ready;
  logic [tepq_pkg::KIND_W-1:0]       kind;
  logic [tepq_pkg::TIME_W-1:0]       event_time;
  logic [tepq_pkg::TAG_PORT_W-1:0]   event_tag;

  modport source (output valid, kind, event_time, event_tag, input ready);
  modport sink   (input valid, kind, event_time, event_tag, output ready);
endinterface

FILE: hdl/tepq_out_if.sv
// ----------------------------------------------------------------------------
// tepq_out_if: result channel of the event queue
// Carries one result item per valid/ready handshake.
// ----------------------------------------------------------------------------
interface tepq_out_if;
  logic                              valid;
  logic                              ready;
  logic                              fired;
  logic [tepq_pkg::TAG_PORT_W-1:0]   fired_tag;
  logic [tepq_pkg::TIME_W-1:0]       next_due_cycle;
  logic                              status;
  logic                              last;

  modport source (output valid, fired, fired_tag, next_due_cycle, status, last,
                  input ready);
  modport sink   (input valid, fired, fired_tag, next_due_cycle, status, last,
                  output ready);
endinterface

FILE: hdl/tepq_ctrl.sv
// ----------------------------------------------------------------------------
// tepq_ctrl: controller of the event queue
// Sequences compare/insert, pop and result emission for one item at a time.
// ----------------------------------------------------------------------------
module tepq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tepq_pkg::dp_sts_t sts,
  output tepq_pkg::dp_cmd_t cmd
);

  tepq_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tepq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tepq_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (sts.in_kind == tepq_pkg::KIND_SCHEDULE) begin
            state_nxt = tepq_pkg::ST_INS_CMP;
          end else if (sts.in_kind == tepq_pkg::KIND_EXPIRE) begin
            state_nxt = tepq_pkg::ST_EXP_CHECK;
          end else begin
            state_nxt = tepq_pkg::ST_EMIT_ONE;
          end
        end
      end
      tepq_pkg::ST_INS_CMP: begin
        state_nxt = sts.full ? tepq_pkg::ST_EMIT_DROP : tepq_pkg::ST_INS_SHIFT;
      end
      tepq_pkg::ST_INS_SHIFT: begin
        state_nxt = tepq_pkg::ST_EMIT_ONE;
      end
      tepq_pkg::ST_EMIT_ONE, tepq_pkg::ST_EMIT_DROP: begin
        if (!sts.out_busy) state_nxt = tepq_pkg::ST_IDLE;
      end
      tepq_pkg::ST_EXP_CHECK: begin
        if (sts.due) begin
          state_nxt = tepq_pkg::ST_EXP_FIRE;
        end else if (!sts.out_busy) begin
          state_nxt = tepq_pkg::ST_IDLE;
        end
      end
      tepq_pkg::ST_EXP_FIRE: begin
        if (!sts.out_busy && !sts.due) state_nxt = tepq_pkg::ST_IDLE;
      end
      default: state_nxt = tepq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      tepq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      tepq_pkg::ST_INS_CMP: begin
        cmd.cmp = 1'b1;
      end
      tepq_pkg::ST_INS_SHIFT: begin
        cmd.ins = 1'b1;
      end
      tepq_pkg::ST_EMIT_ONE: begin
        cmd.emit      = !sts.out_busy;
        cmd.emit_last = 1'b1;
      end
      tepq_pkg::ST_EMIT_DROP: begin
        cmd.emit        = !sts.out_busy;
        cmd.emit_status = 1'b1;
        cmd.emit_last   = 1'b1;
      end
      tepq_pkg::ST_EXP_CHECK: begin
        // nothing due: report a single empty result
        cmd.pop       = sts.due;
        cmd.emit      = !sts.due && !sts.out_busy;
        cmd.emit_last = 1'b1;
      end
      tepq_pkg::ST_EXP_FIRE: begin
        // emit the popped tag and pop the next due entry in the same cycle
        cmd.emit       = !sts.out_busy;
        cmd.emit_fired = 1'b1;
        cmd.emit_last  = !sts.due;
        cmd.pop        = !sts.out_busy && sts.due;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: hdl/tepq_dp.sv
// ----------------------------------------------------------------------------
// tepq_dp: datapath of the event queue
// Sorted row of entry cells, entry count, end cycle and the result register.
// ----------------------------------------------------------------------------
module tepq_dp #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_WIDTH   = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tepq_pkg::TIME_W-1:0]       cfg_wdata,
  input  logic [tepq_pkg::KIND_W-1:0]       in_kind,
  input  logic [tepq_pkg::TIME_W-1:0]       in_event_time,
  input  logic [tepq_pkg::TAG_PORT_W-1:0]   in_event_tag,
  input  tepq_pkg::dp_cmd_t                 cmd,
  output tepq_pkg::dp_sts_t                 sts,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic                              out_fired,
  output logic [tepq_pkg::TAG_PORT_W-1:0]   out_fired_tag,
  output logic [tepq_pkg::TIME_W-1:0]       out_next_due_cycle,
  output logic                              out_status,
  output logic                              out_last
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [tepq_pkg::TIME_W-1:0] end_cycle_r;
  logic [CW-1:0]               count_r;
  logic [tepq_pkg::TIME_W-1:0] time_r;
  logic [TAG_WIDTH-1:0]        tag_r;
  logic [tepq_pkg::TIME_W-1:0] times_r [QUEUE_DEPTH];
  logic [TAG_WIDTH-1:0]        tags_r  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]      gt_r;
  logic [TAG_WIDTH-1:0]        pop_tag_r;

  logic                              out_valid_r;
  logic                              out_fired_r;
  logic [tepq_pkg::TAG_PORT_W-1:0]   out_tag_r;
  logic [tepq_pkg::TIME_W-1:0]       out_due_r;
  logic                              out_status_r;
  logic                              out_last_r;

  logic [TAG_WIDTH-1:0]              tag_in;
  logic [tepq_pkg::TAG_PORT_W-1:0]   tag_out_ext;
  logic                              empty;
  logic [tepq_pkg::TIME_W-1:0]       next_due;

  // only the low min(TAG_WIDTH, TAG_PORT_W) bits of a tag survive, in either direction
  for (genvar b = 0; b < TAG_WIDTH; b++) begin : g_tag_in
    if (b < tepq_pkg::TAG_PORT_W) begin : g_bit
      assign tag_in[b] = in_event_tag[b];
    end else begin : g_zero
      assign tag_in[b] = 1'b0;
    end
  end

  for (genvar b = 0; b < tepq_pkg::TAG_PORT_W; b++) begin : g_tag_out
    if (b < TAG_WIDTH) begin : g_bit
      assign tag_out_ext[b] = pop_tag_r[b];
    end else begin : g_zero
      assign tag_out_ext[b] = 1'b0;
    end
  end

  assign empty    = (count_r == '0);
  assign next_due = (empty || !(times_r[0] < end_cycle_r)) ? end_cycle_r : times_r[0];

  assign sts.in_kind  = in_kind;
  assign sts.full     = (count_r == CW'(QUEUE_DEPTH));
  assign sts.due      = !empty && (times_r[0] <= time_r);
  assign sts.out_busy = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_cycle_r <= '0;
      count_r     <= '0;
    end else begin
      if (cfg_we) end_cycle_r <= cfg_wdata;
      if (cmd.ins) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.pop) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      time_r <= in_event_time;
      tag_r  <= tag_in;
    end
    if (cmd.pop) pop_tag_r <= tags_r[0];
  end

  // each cell shifts up behind the insertion point; all but the tail cell shift down on a pop
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    always_ff @(posedge clk) begin
      if (cmd.cmp) gt_r[i] <= (CW'(i) >= count_r) || (times_r[i] > time_r);
    end

    if (i == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (cmd.ins && gt_r[i]) begin
          times_r[i] <= time_r;
          tags_r[i]  <= tag_r;
        end else if (cmd.pop) begin
          times_r[i] <= times_r[i+1];
          tags_r[i]  <= tags_r[i+1];
        end
      end
    end else if (i == QUEUE_DEPTH - 1) begin : g_tail
      always_ff @(posedge clk) begin
        if (cmd.ins && gt_r[i]) begin
          times_r[i] <= gt_r[i-1] ? times_r[i-1] : time_r;
          tags_r[i]  <= gt_r[i-1] ? tags_r[i-1]  : tag_r;
        end
      end
    end else begin : g_mid
      always_ff @(posedge clk) begin
        if (cmd.ins && gt_r[i]) begin
          times_r[i] <= gt_r[i-1] ? times_r[i-1] : time_r;
          tags_r[i]  <= gt_r[i-1] ? tags_r[i-1]  : tag_r;
        end else if (cmd.pop) begin
          times_r[i] <= times_r[i+1];
          tags_r[i]  <= tags_r[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_fired_r  <= cmd.emit_fired;
      out_tag_r    <= cmd.emit_fired ? tag_out_ext : '0;
      out_due_r    <= next_due;
      out_status_r <= cmd.emit_status;
      out_last_r   <= cmd.emit_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_fired          = out_fired_r;
  assign out_fired_tag      = out_tag_r;
  assign out_next_due_cycle = out_due_r;
  assign out_status         = out_status_r;
  assign out_last           = out_last_r;

endmodule

FILE: hdl/timed_event_priority_queue.sv
// ----------------------------------------------------------------------------
// timed_event_priority_queue: time-ordered event queue for a scheduler
// Holds up to QUEUE_DEPTH events sorted by time (ties in insertion order);
// schedules, expires due events earliest first, and reports the next due
// cycle capped by the end cycle.
//
//   channel   direction  handshake      contents
//   in_chan   sink       valid/ready    kind, event_time, event_tag
//   out_chan  source     valid/ready    fired, fired_tag, next_due_cycle,
//                                       status, last
//   cfg_*     sink       write enable   end cycle
//
// Schedule: accept, parallel compare, shift-insert, emit; a schedule dropped
// on a full queue skips the shift-insert. Query: accept, emit. Expire: accept,
// check, then one pop per cycle of the sorted cell row while no result waits.
// Synchronous active-low reset empties the queue and clears the end cycle.
// One item is worked at a time; a result waits in the output register
// while the next item is accepted, and emission stalls while it is unread.
// ----------------------------------------------------------------------------
module timed_event_priority_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_WIDTH   = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  tepq_in_if.sink                       in_chan,
  tepq_out_if.source                    out_chan,
  input  logic                          cfg_we,
  input  logic [tepq_pkg::TIME_W-1:0]   cfg_wdata
);

  tepq_pkg::dp_cmd_t cmd;
  tepq_pkg::dp_sts_t sts;
  logic              in_ready;

  assign in_chan.ready = in_ready;

  tepq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tepq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_WIDTH   (TAG_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_kind            (in_chan.kind),
    .in_event_time      (in_chan.event_time),
    .in_event_tag       (in_chan.event_tag),
    .cmd                (cmd),
    .sts                (sts),
    .out_ready          (out_chan.ready),
    .out_valid          (out_chan.valid),
    .out_fired          (out_chan.fired),
    .out_fired_tag      (out_chan.fired_tag),
    .out_next_due_cycle (out_chan.next_due_cycle),
    .out_status         (out_chan.status),
    .out_last           (out_chan.last)
  );

  // never overwrite a result that is still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !sts.out_busy)
    else $error("result register overwritten while pending");

  a_pop_due: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> sts.due)
    else $error("pop of an entry that is not due");

  a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |-> !sts.full)
    else $error("insert into a full queue");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_ready) |=> !in_ready)
    else $error("new item accepted while one is in progress");

endmodule
